/* src/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on the rising clock edge outside reset
`define MINV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be true outside reset
`define MINV_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* src/minv_pkg.sv */
// package with the command and status types of the modular inverse unit
`default_nettype none

package minv_pkg;

   typedef struct packed {
      logic load;
      logic special;
      logic prep;
      logic iterate;
      logic update;
      logic reduce;
   } cmd_type;

   typedef struct packed {
      logic value_zero;
      logic modulus_zero;
      logic rem_zero;
   } status_type;

endpackage

`default_nettype wire

/* src/minv_datapath.sv */
// datapath of the modular inverse unit: remainder and coefficient registers, shift-subtract divider
`default_nettype none

module minv_datapath #(
   parameter int DATA_WIDTH = 31
) (
   input  wire logic                      clock,
   input  wire minv_pkg::cmd_type         cmd,
   input  wire logic [DATA_WIDTH-1:0]     req_value,
   input  wire logic [DATA_WIDTH-1:0]     req_modulus,
   output minv_pkg::status_type           status,
   output logic      [DATA_WIDTH-1:0]     rsp_inverse
);

   localparam int W = DATA_WIDTH;

   logic        [W-1:0]   m_ff, m_in;
   logic        [W-1:0]   r_prev_ff, r_prev_in;
   logic        [W-1:0]   r_cur_ff, r_cur_in;
   logic        [W-1:0]   rem_ff, rem_in;
   logic        [2*W-2:0] d_ff, d_in;
   logic signed [W:0]     s_prev_ff, s_prev_in;
   logic signed [W:0]     s_cur_ff, s_cur_in;
   logic signed [W:0]     s_acc_ff, s_acc_in;
   logic signed [2*W-1:0] sd_ff, sd_in;
   logic        [W-1:0]   result_ff, result_in;

   logic                  take_bit;
   logic        [W:0]     s_neg;
   logic        [W:0]     m_ext;
   logic        [W-1:0]   reduced;

   assign take_bit = d_ff <= {{(W-1){1'b0}}, rem_ff};
   assign s_neg    = (W+1)'(0) - s_prev_ff;
   assign m_ext    = {1'b0, m_ff};

   // coefficient lies in [-m, m]: fold into [0, m-1]
   always_comb begin
      if (s_prev_ff[W]) begin
         if (s_neg == m_ext || s_neg == '0) begin
            reduced = '0;
         end else begin
            reduced = m_ff - s_neg[W-1:0];
         end
      end else begin
         if (s_prev_ff == m_ext) begin
            reduced = '0;
         end else begin
            reduced = s_prev_ff[W-1:0];
         end
      end
   end

   always_comb begin
      m_in      = m_ff;
      r_prev_in = r_prev_ff;
      r_cur_in  = r_cur_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      s_prev_in = s_prev_ff;
      s_cur_in  = s_cur_ff;
      s_acc_in  = s_acc_ff;
      sd_in     = sd_ff;
      result_in = result_ff;
      if (cmd.load) begin
         m_in      = req_modulus;
         r_prev_in = req_modulus;
         r_cur_in  = req_value;
         s_prev_in = '0;
         s_cur_in  = (W+1)'(1);
      end
      if (cmd.special) begin
         // zero value gives 1 mod m, zero modulus gives 0
         if (r_cur_ff == '0 && m_ff > W'(1)) begin
            result_in = W'(1);
         end else begin
            result_in = '0;
         end
      end
      if (cmd.prep) begin
         rem_in   = r_prev_ff;
         d_in     = {r_cur_ff, {(W-1){1'b0}}};
         sd_in    = {s_cur_ff, {(W-1){1'b0}}};
         s_acc_in = s_prev_ff;
      end
      if (cmd.iterate) begin
         if (take_bit) begin
            rem_in   = rem_ff - d_ff[W-1:0];
            s_acc_in = s_acc_ff - sd_ff[W:0];
         end
         d_in  = d_ff >> 1;
         sd_in = sd_ff >>> 1;
      end
      if (cmd.update) begin
         r_prev_in = r_cur_ff;
         r_cur_in  = rem_ff;
         s_prev_in = s_cur_ff;
         s_cur_in  = s_acc_ff;
      end
      if (cmd.reduce) begin
         result_in = reduced;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      r_prev_ff <= r_prev_in;
      r_cur_ff  <= r_cur_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      s_prev_ff <= s_prev_in;
      s_cur_ff  <= s_cur_in;
      s_acc_ff  <= s_acc_in;
      sd_ff     <= sd_in;
      result_ff <= result_in;
   end

   assign status.value_zero   = r_cur_ff == '0;
   assign status.modulus_zero = m_ff == '0;
   assign status.rem_zero     = rem_ff == '0;
   assign rsp_inverse         = result_ff;

endmodule

`default_nettype wire

/* src/minv_controller.sv */
// controller state machine of the modular inverse unit
`default_nettype none

module minv_controller #(
   parameter int DATA_WIDTH = 31
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire minv_pkg::status_type status,
   output minv_pkg::cmd_type         cmd,
   output logic                      busy,
   output logic                      rsp_strobe
);

   localparam int CW = $clog2(DATA_WIDTH);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      PREP,
      DIVIDE,
      UPDATE,
      REDUCE
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   count_ff;
   logic            busy_ff;
   logic            strobe_ff;

   always_comb begin
      cmd         = '0;
      cmd.load    = state_ff == IDLE && start && !busy_ff;
      cmd.special = state_ff == CHECK && (status.value_zero || status.modulus_zero);
      cmd.prep    = state_ff == PREP;
      cmd.iterate = state_ff == DIVIDE;
      cmd.update  = state_ff == UPDATE;
      cmd.reduce  = state_ff == REDUCE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start && !busy_ff) begin
                  busy_ff  <= 1'b1;
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               if (status.value_zero || status.modulus_zero) begin
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
                  state_ff  <= IDLE;
               end else begin
                  state_ff <= PREP;
               end
            end
            PREP: begin
               count_ff <= CW'(DATA_WIDTH - 1);
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               count_ff <= count_ff - CW'(1);
               if (count_ff == '0) begin
                  state_ff <= UPDATE;
               end
            end
            UPDATE: begin
               // new divisor is the remainder just found
               if (status.rem_zero) begin
                  state_ff <= REDUCE;
               end else begin
                  state_ff <= PREP;
               end
            end
            REDUCE: begin
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b1;
               state_ff  <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

/* src/modular_inverse_unit.sv */
// top level of the modular inverse unit
//
// computes the inverse of req_value modulo req_modulus by the extended
// euclidean algorithm and returns it on rsp_inverse in [0, modulus-1].
// a transfer is taken at a rising edge with start high and busy low;
// busy then stays high until the result is issued.
// the result is on rsp_inverse for one cycle with rsp_strobe high and is
// taken at the edge that ends that cycle; the receiver cannot stall.
// a zero value or zero modulus skips the division and gives its result
// from the check state; otherwise euclid steps run until a remainder is zero,
// at most 45 steps for 31-bit operands.
// each euclid step is one restoring division, one quotient bit per cycle,
// which also subtracts the shifted coefficient, so no multiplier is used.
// busy falls in the strobe cycle, so the next start can be taken then.
// reset returns the controller to idle with busy and rsp_strobe low.
`default_nettype none
`include "assert_macros.svh"

module modular_inverse_unit #(
   parameter int DATA_WIDTH = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DATA_WIDTH-1:0] req_value,
   input  wire logic [DATA_WIDTH-1:0] req_modulus,
   output logic                       rsp_strobe,
   output logic      [DATA_WIDTH-1:0] rsp_inverse
);

   minv_pkg::cmd_type    cmd;
   minv_pkg::status_type status;

   minv_controller #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   minv_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .req_value   (req_value),
      .req_modulus (req_modulus),
      .status      (status),
      .rsp_inverse (rsp_inverse)
   );

   `MINV_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after transfer")
   `MINV_ASSERT(a_reduce_strobe, cmd.reduce |=> (rsp_strobe && !busy), "no result after reduce")
   `MINV_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
   `MINV_NEVER(a_strobe_busy, rsp_strobe && busy, "result strobe while busy")

endmodule

`default_nettype wire
